// ===== hw/rtl/ddrd_pkg.sv =====
// ----------------------------------------------------------------------------
// ddrd_pkg: shared types and codes of the debug request deframer
// Beat structs of both channels, command bytes, result kinds and
// header positions.
// ----------------------------------------------------------------------------
`default_nettype none

package ddrd_pkg;

  // Command bytes that open a frame.
  localparam logic [7:0] CMD_READ  = 8'h0A;
  localparam logic [7:0] CMD_WRITE = 8'h09;

  // Result kinds.
  localparam logic [1:0] KIND_READ_REQ  = 2'd0;
  localparam logic [1:0] KIND_WRITE_DAT = 2'd1;
  localparam logic [1:0] KIND_ERROR     = 2'd2;

  // Frame command held while a frame is parsed.
  localparam logic [1:0] FRM_NONE  = 2'd0;
  localparam logic [1:0] FRM_READ  = 2'd1;
  localparam logic [1:0] FRM_WRITE = 2'd2;

  // Header positions.
  localparam logic [3:0] POS_CMD       = 4'd0;
  localparam logic [3:0] POS_RD_LEN_HI = 4'd4;
  localparam logic [3:0] POS_RD_LEN_LO = 4'd5;
  localparam logic [3:0] POS_RD_ADR_HI = 4'd6;
  localparam logic [3:0] POS_RD_ADR_LO = 4'd7;
  localparam logic [3:0] POS_WR_LEN_HI = 4'd6;
  localparam logic [3:0] POS_WR_LEN_LO = 4'd7;
  localparam logic [3:0] POS_WR_ADR_HI = 4'd8;
  localparam logic [3:0] POS_WR_ADR_LO = 4'd9;
  localparam logic [3:0] POS_PAYLOAD   = 4'd10;
  localparam logic [3:0] RD_HDR_LEN    = 4'd8;

  // One input beat.
  typedef struct packed {
    logic [7:0] stream_byte;
    logic       new_connection;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  request_kind;
    logic [15:0] target_address;
    logic [15:0] read_length;
    logic [7:0]  write_data;
    logic        last_of_write;
  } out_beat_t;

  // Input register contents handed to the parser.
  typedef struct packed {
    logic     valid;
    in_beat_t beat;
  } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ddrd_in_reg.sv =====
// ----------------------------------------------------------------------------
// ddrd_in_reg: input register of the debug request deframer
// Captures one input beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrd_in_reg
  import ddrd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_beat,
  input  wire logic     advance,
  output stage_t        stage
);

  logic     valid_r;
  in_beat_t beat_r;

  // A held beat blocks the input until the parser moves it on.
  assign in_stall = valid_r && !advance;

  // Load a new beat whenever the register is free or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      beat_r <= in_beat;
    end
  end

  assign stage.valid = valid_r;
  assign stage.beat  = beat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ddrd_parser.sv =====
// ----------------------------------------------------------------------------
// ddrd_parser: frame parser and result register
// Walks the read and write frame headers one byte at a time and loads
// read requests, write records and error results into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddrd_parser
  import ddrd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stage_t stage,
  input  wire logic   out_stall,
  output logic        advance,
  output logic        out_valid,
  output out_beat_t   out_beat
);

  logic [3:0]  pos_r, pos_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic        halt_r, halt_nxt;
  logic        out_valid_r;
  out_beat_t   out_beat_r;
  logic        emit;
  out_beat_t   res;
  logic [7:0]  b;
  logic [15:0] offset;
  logic        take;

  // The result register frees up when it is empty or its beat is taken.
  assign advance = !out_valid_r || !out_stall;
  assign take    = stage.valid && advance;
  assign b       = stage.beat.stream_byte;
  assign offset  = len_r - rem_r;

  // Next parser state and result for the held byte.
  always_comb begin
    pos_nxt  = pos_r;
    cmd_nxt  = cmd_r;
    len_nxt  = len_r;
    addr_nxt = addr_r;
    rem_nxt  = rem_r;
    halt_nxt = halt_r;
    emit     = 1'b0;
    res      = '0;

    // A new connection restarts the parser ahead of this byte.
    if (stage.beat.new_connection) begin
      pos_nxt  = POS_CMD;
      cmd_nxt  = FRM_NONE;
      halt_nxt = 1'b0;
    end

    if (!halt_nxt) begin
      if (pos_nxt == POS_CMD) begin
        if (b == CMD_READ) begin
          cmd_nxt = FRM_READ;
          pos_nxt = 4'd1;
        end else if (b == CMD_WRITE) begin
          cmd_nxt = FRM_WRITE;
          pos_nxt = 4'd1;
        end else begin
          halt_nxt = 1'b1;
          cmd_nxt  = FRM_NONE;
          emit     = 1'b1;
          res.request_kind = KIND_ERROR;
        end
      end else if (cmd_nxt == FRM_READ && pos_nxt < RD_HDR_LEN) begin
        // Read header: length then address, both big-endian.
        case (pos_nxt)
          POS_RD_LEN_HI: len_nxt[15:8]  = b;
          POS_RD_LEN_LO: len_nxt[7:0]   = b;
          POS_RD_ADR_HI: addr_nxt[15:8] = b;
          POS_RD_ADR_LO: addr_nxt[7:0]  = b;
          default: ;
        endcase
        if (pos_nxt == POS_RD_ADR_LO) begin
          pos_nxt = POS_CMD;
          cmd_nxt = FRM_NONE;
          emit    = 1'b1;
          res.request_kind   = KIND_READ_REQ;
          res.target_address = {addr_r[15:8], b};
          res.read_length    = len_r;
        end else begin
          pos_nxt = pos_nxt + 4'd1;
        end
      end else if (cmd_nxt == FRM_WRITE && pos_nxt < POS_PAYLOAD) begin
        // Write header: length then address, both big-endian.
        case (pos_nxt)
          POS_WR_LEN_HI: len_nxt[15:8]  = b;
          POS_WR_LEN_LO: len_nxt[7:0]   = b;
          POS_WR_ADR_HI: addr_nxt[15:8] = b;
          POS_WR_ADR_LO: addr_nxt[7:0]  = b;
          default: ;
        endcase
        if (pos_nxt == POS_WR_ADR_LO) begin
          rem_nxt = len_r;
          if (len_r == 16'd0) begin
            pos_nxt = POS_CMD;
            cmd_nxt = FRM_NONE;
          end else begin
            pos_nxt = POS_PAYLOAD;
          end
        end else begin
          pos_nxt = pos_nxt + 4'd1;
        end
      end else if (cmd_nxt == FRM_WRITE && pos_nxt == POS_PAYLOAD && rem_r != 16'd0) begin
        // Payload byte: one write record each.
        rem_nxt = rem_r - 16'd1;
        if (rem_r == 16'd1) begin
          pos_nxt = POS_CMD;
          cmd_nxt = FRM_NONE;
        end
        emit = 1'b1;
        res.request_kind   = KIND_WRITE_DAT;
        res.target_address = addr_r + offset;
        res.write_data     = b;
        res.last_of_write  = (rem_r == 16'd1);
      end else begin
        // A position that does not fit the command drops the byte.
        pos_nxt = POS_CMD;
        cmd_nxt = FRM_NONE;
      end
    end
  end

  // Parser state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_CMD;
      cmd_r       <= FRM_NONE;
      len_r       <= '0;
      addr_r      <= '0;
      rem_r       <= '0;
      halt_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= take && emit;
      if (take) begin
        pos_r  <= pos_nxt;
        cmd_r  <= cmd_nxt;
        len_r  <= len_nxt;
        addr_r <= addr_nxt;
        rem_r  <= rem_nxt;
        halt_r <= halt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_beat_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

`ifndef SYNTH
  // An error result leaves the parser halted.
  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit && res.request_kind == KIND_ERROR) |=> halt_r)
    else $error("error result did not halt the parser");

  // A halted parser waits at the command position.
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> (pos_r == POS_CMD && cmd_r == FRM_NONE))
    else $error("halted parser is not idle");

  // The payload phase belongs to a write with bytes still due.
  a_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_PAYLOAD) |-> (cmd_r == FRM_WRITE && rem_r != 16'd0))
    else $error("payload phase outside a write frame");

  // Only write records carry the last flag.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_beat_r.last_of_write) |->
      (out_beat_r.request_kind == KIND_WRITE_DAT))
    else $error("last flag on a non-write result");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/dsp_debug_request_deframer_top.sv =====
// ----------------------------------------------------------------------------
// dsp_debug_request_deframer_top: DSP debug link request deframer
// Parses the request byte stream into read requests, write records and
// error results.
// ----------------------------------------------------------------------------
// The block takes one request byte per clock while in_stall is low and gives
// at most one result per byte; each byte passes through the input register,
// then the frame parser, and its result through the result register. A read
// frame yields one read request when its last header byte arrives, each write
// payload byte yields one write record, and an unknown command yields one
// error result, after which bytes are dropped until a beat with
// new_connection set. Stall on a full result register holds the input
// register. If the input register already holds a beat, the input is
// stalled in that same cycle; if it is empty, it takes one more beat first.
`default_nettype none

module dsp_debug_request_deframer_top
  import ddrd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_beat_t in_beat,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_beat_t     out_beat
);

  stage_t stage;
  logic   advance;

  // Input register.
  ddrd_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .advance  (advance),
    .stage    (stage)
  );

  // Frame parser and result register.
  ddrd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .out_stall (out_stall),
    .advance   (advance),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

endmodule

`default_nettype wire
